>>> hdl/dctg_pkg.sv
// Shared constants and types for the duty-cycle tone generator.
// No dependencies; every other file of the block but the response interface and the checker imports this package.
package dctg_pkg;

    localparam int unsigned CounterWidth = 32;
    localparam int unsigned TickRateW    = 32;
    localparam int unsigned FreqW        = 32;
    localparam int unsigned DutyW        = 8;
    localparam int unsigned PhaseW       = 32;
    // A duty that passes the range check is below 100 and fits in 7 bits.
    localparam int unsigned DutyBits     = 7;
    localparam int unsigned MulW         = FreqW + DutyBits;
    localparam int unsigned DivW         = MulW + 1;
    localparam int unsigned DivisorW     = FreqW;
    localparam int unsigned CmpW         = (CounterWidth > PhaseW) ? CounterWidth : PhaseW;

    localparam int unsigned PctScale     = 100;
    localparam int unsigned MinPeriod    = 2;
    localparam logic [TickRateW-1:0] ResetTickRate = TickRateW'(1000000);

    localparam int unsigned ApbAddrW     = 2;
    localparam int unsigned ApbDataW     = 32;
    localparam logic [ApbAddrW-1:0] AddrTickRate = '0;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2
    } t_opcode;

endpackage

>>> hdl/dctg_cmd_if.sv
// Command channel of the tone generator: tick, start and stop requests.
// Depends on dctg_pkg for the field widths.
interface dctg_cmd_if;
    import dctg_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          opcode;
    logic [FreqW-1:0]    tone_freq;
    logic [DutyW-1:0]    duty_pct;

    modport source (output valid, opcode, tone_freq, duty_pct, input ready);
    modport sink   (input valid, opcode, tone_freq, duty_pct, output ready);
endinterface

>>> hdl/dctg_rsp_if.sv
// Response channel of the tone generator: one result per request.
// No package dependency; all fields are single bits.
interface dctg_rsp_if;
    logic valid;
    logic ready;
    logic tone_level;
    logic tone_active;
    logic status;

    modport source (output valid, tone_level, tone_active, status, input ready);
    modport sink   (input valid, tone_level, tone_active, status, output ready);
endinterface

>>> hdl/dctg_cfg.sv
// APB-style register file holding the tick rate.
// Depends on dctg_pkg for the address map and reset value.
module dctg_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dctg_pkg::ApbAddrW-1:0] paddr,
    input  logic [dctg_pkg::ApbDataW-1:0] pwdata,
    output logic [dctg_pkg::ApbDataW-1:0] prdata,
    output logic                          pready,
    output logic [dctg_pkg::TickRateW-1:0] o_tick_rate
);
    import dctg_pkg::*;

    logic [TickRateW-1:0] r_tick_rate;
    logic                 wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & (paddr == AddrTickRate);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_rate <= ResetTickRate;
        end else if (wr_en) begin
            r_tick_rate <= pwdata[TickRateW-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == AddrTickRate) begin
            prdata = ApbDataW'(r_tick_rate);
        end
    end

    assign o_tick_rate = r_tick_rate;
endmodule

>>> hdl/dctg_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on dctg_pkg for the dividend and divisor widths.
module dctg_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dctg_pkg::DivW-1:0]     i_dividend,
    input  logic [dctg_pkg::DivisorW-1:0] i_divisor,
    output logic                          o_done,
    output logic [dctg_pkg::DivW-1:0]     o_quotient
);
    import dctg_pkg::*;

    localparam int unsigned CntW = $clog2(DivW);

    logic [DivisorW-1:0] r_rem;
    logic [DivisorW-1:0] r_div;
    logic [DivW-1:0]     r_quo;
    logic [CntW-1:0]     r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [DivisorW:0]   trial;
    logic [DivisorW:0]   diff;
    logic                ge;

    // The remainder stays below the divisor, so the trial value needs one extra bit.
    assign trial = {r_rem, r_quo[DivW-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(DivW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
            r_quo <= {r_quo[DivW-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

>>> hdl/dctg_mul.sv
// Shift-and-add multiplier for period times duty, one duty bit per cycle.
// Depends on dctg_pkg for the operand widths.
module dctg_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dctg_pkg::FreqW-1:0]    i_mcand,
    input  logic [dctg_pkg::DutyBits-1:0] i_mplier,
    output logic                          o_done,
    output logic [dctg_pkg::MulW-1:0]     o_product
);
    import dctg_pkg::*;

    localparam int unsigned CntW = $clog2(DutyBits);

    logic [MulW-1:0]     r_acc;
    logic [MulW-1:0]     r_mcand;
    logic [DutyBits-1:0] r_mplier;
    logic [CntW-1:0]     r_cnt;
    logic                r_busy;
    logic                r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(DutyBits - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= MulW'(i_mcand);
            r_mplier <= i_mplier;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[MulW-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[DutyBits-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;
endmodule

>>> hdl/duty_cycle_tone_generator.sv
// Duty-cycle square-wave tone generator, top level with the request sequencer.
// Tick, stop and unknown requests: the result is registered on acceptance.
// Start: two 40-step serial divisions and a 7-step serial multiply, then the result state;
// a start rejected by the range checks is answered like a tick, a too-short period after the first division.
// One request in work at a time; the next is taken once the result leaves, up to one per cycle.
// Synchronous active-low reset: tone idle, output low, tick rate 1000000.
module duty_cycle_tone_generator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    dctg_cmd_if.sink                       i_cmd,
    dctg_rsp_if.source                     o_rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dctg_pkg::ApbAddrW-1:0]  paddr,
    input  logic [dctg_pkg::ApbDataW-1:0]  pwdata,
    output logic [dctg_pkg::ApbDataW-1:0]  prdata,
    output logic                           pready
);
    import dctg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_PERIOD,
        S_MUL,
        S_DIV_HIGH,
        S_RESULT
    } t_state;

    t_state                  r_state;
    logic                    r_running;
    logic                    r_level;
    logic [PhaseW-1:0]       r_high;
    logic [PhaseW-1:0]       r_low;
    logic [CounterWidth-1:0] r_phase;
    logic [PhaseW-1:0]       r_period;
    logic [DutyBits-1:0]     r_duty;
    logic                    r_res_status;
    logic                    r_out_valid;
    logic                    r_out_level;
    logic                    r_out_active;
    logic                    r_out_status;

    logic [TickRateW-1:0]    tick_rate;
    logic                    cmd_fire;
    logic                    out_free;
    logic                    pre_bad;
    logic [PhaseW-1:0]       len;
    logic [CounterWidth-1:0] cnt_inc;
    logic                    wrap;

    logic                    div_start;
    logic [DivW-1:0]         div_dividend;
    logic [DivisorW-1:0]     div_divisor;
    logic                    div_done;
    logic [DivW-1:0]         div_quo;
    logic                    mul_start;
    logic                    mul_done;
    logic [MulW-1:0]         mul_prod;

    logic                    period_ok;
    logic [PhaseW-1:0]       hi_ticks;
    logic [PhaseW-1:0]       lo_ticks;
    logic                    phase_bad;

    dctg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_tick_rate (tick_rate)
    );

    dctg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    dctg_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_mcand   (div_quo[FreqW-1:0]),
        .i_mplier  (r_duty),
        .o_done    (mul_done),
        .o_product (mul_prod)
    );

    assign out_free     = !r_out_valid || o_rsp.ready;
    assign i_cmd.ready  = (r_state == S_IDLE) && out_free;
    assign cmd_fire     = i_cmd.valid && i_cmd.ready;

    assign pre_bad = (i_cmd.tone_freq == '0) || (i_cmd.duty_pct == '0) ||
                     (i_cmd.duty_pct >= DutyW'(PctScale)) ||
                     (tick_rate < i_cmd.tone_freq);

    // Tick: advance within the current phase and flip the level at its end.
    assign len     = r_level ? r_high : r_low;
    assign cnt_inc = r_phase + 1'b1;
    assign wrap    = (CmpW'(cnt_inc) >= CmpW'(len));

    // The first division runs from the idle state, the second right after the multiply.
    assign div_start    = (cmd_fire && (i_cmd.opcode == OP_START) && !pre_bad) ||
                          ((r_state == S_MUL) && mul_done);
    assign div_dividend = (r_state == S_IDLE) ? DivW'(tick_rate) : DivW'(mul_prod);
    assign div_divisor  = (r_state == S_IDLE) ? i_cmd.tone_freq : DivisorW'(PctScale);

    assign period_ok = (div_quo >= DivW'(MinPeriod));
    assign mul_start = (r_state == S_DIV_PERIOD) && div_done && period_ok;

    assign hi_ticks  = div_quo[PhaseW-1:0];
    assign lo_ticks  = r_period - hi_ticks;
    assign phase_bad = (hi_ticks == '0) || (lo_ticks == '0) ||
                       ((CmpW'(hi_ticks) >> CounterWidth) != '0) ||
                       ((CmpW'(lo_ticks) >> CounterWidth) != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_running    <= 1'b0;
            r_level      <= 1'b0;
            r_high       <= PhaseW'(1);
            r_low        <= PhaseW'(1);
            r_phase      <= '0;
            r_res_status <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_level  <= 1'b0;
            r_out_active <= 1'b0;
            r_out_status <= 1'b0;
        end else begin
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (cmd_fire) begin
                        case (i_cmd.opcode)
                            OP_TICK: begin
                                r_out_valid  <= 1'b1;
                                r_out_active <= r_running;
                                r_out_status <= 1'b0;
                                r_out_level  <= r_level;
                                if (r_running) begin
                                    if (wrap) begin
                                        r_level     <= !r_level;
                                        r_phase     <= '0;
                                        r_out_level <= !r_level;
                                    end else begin
                                        r_phase <= cnt_inc;
                                    end
                                end
                            end
                            OP_START: begin
                                if (pre_bad) begin
                                    r_out_valid  <= 1'b1;
                                    r_out_level  <= r_level;
                                    r_out_active <= r_running;
                                    r_out_status <= 1'b1;
                                end else begin
                                    r_duty  <= i_cmd.duty_pct[DutyBits-1:0];
                                    r_state <= S_DIV_PERIOD;
                                end
                            end
                            OP_STOP: begin
                                r_running    <= 1'b0;
                                r_level      <= 1'b0;
                                r_phase      <= '0;
                                r_out_valid  <= 1'b1;
                                r_out_level  <= 1'b0;
                                r_out_active <= 1'b0;
                                r_out_status <= 1'b0;
                            end
                            default: begin
                                r_out_valid  <= 1'b1;
                                r_out_level  <= r_level;
                                r_out_active <= r_running;
                                r_out_status <= 1'b0;
                            end
                        endcase
                    end
                end
                S_DIV_PERIOD: begin
                    if (div_done) begin
                        if (period_ok) begin
                            r_period <= div_quo[PhaseW-1:0];
                            r_state  <= S_MUL;
                        end else begin
                            r_res_status <= 1'b1;
                            r_state      <= S_RESULT;
                        end
                    end
                end
                S_MUL: begin
                    if (mul_done) begin
                        r_state <= S_DIV_HIGH;
                    end
                end
                S_DIV_HIGH: begin
                    if (div_done) begin
                        r_res_status <= phase_bad;
                        if (!phase_bad) begin
                            r_high    <= hi_ticks;
                            r_low     <= lo_ticks;
                            r_level   <= 1'b0;
                            r_phase   <= '0;
                            r_running <= 1'b1;
                        end
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_level  <= r_level;
                        r_out_active <= r_running;
                        r_out_status <= r_res_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.tone_level  = r_out_level;
    assign o_rsp.tone_active = r_out_active;
    assign o_rsp.status      = r_out_status;
endmodule

>>> hdl/dctg_checker.sv
// Port-level checks for the tone generator, bound to the top level.
// Depends only on the top level's ports.
module dctg_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input logic i_tone_level,
    input logic i_tone_active,
    input logic i_status,
    input logic i_pready
);

    // A stalled result holds its value.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_tone_level) && $stable(i_tone_active) &&
            $stable(i_status))
        else $error("result changed while stalled");

    // An idle tone always reports a low output.
    a_idle_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_tone_active |-> !i_tone_level)
        else $error("idle tone reports a high level");

    // No result is offered in the first cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> !i_rsp_valid)
        else $error("result offered right after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("configuration port stalled");

endmodule

bind duty_cycle_tone_generator dctg_checker u_dctg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_tone_level  (o_rsp.tone_level),
    .i_tone_active (o_rsp.tone_active),
    .i_status      (o_rsp.status),
    .i_pready      (pready)
);
